// File: rtl/life_grid_generation_step_defines.svh
// assertion macros for the life grid generation step block
`ifndef LIFE_GRID_GENERATION_STEP_DEFINES_SVH
`define LIFE_GRID_GENERATION_STEP_DEFINES_SVH

`ifndef SYNTHESIS
`define LGS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("life grid assertion failed");
`define LGS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("life grid assertion failed");
`else
`define LGS_ASSERT_SAME(label, ante, cons)
`define LGS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/lgs_pkg.sv
// shared types and constants for the life grid generation step block
package lgs_pkg;

  localparam int GRID_SIZE_DEF = 64;
  localparam int ROW_W = 6;
  localparam int COL_W = 6;
  localparam int NBR_W = 4;

  localparam logic [NBR_W-1:0] BIRTH_COUNT   = NBR_W'(3);
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = NBR_W'(2);

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_SET     = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// File: rtl/lgs_row_cell.sv
// one row of the grid ring, handed on to its neighbor on each shift
module lgs_row_cell #(
  parameter int GRID_SIZE = lgs_pkg::GRID_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lgs_pkg::cell_ctl_t    ctl,
  input  logic [GRID_SIZE-1:0]  shift_in,
  input  logic [GRID_SIZE-1:0]  load_row,
  output logic [GRID_SIZE-1:0]  row_out
);

  logic [GRID_SIZE-1:0] row_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      row_r <= '0;
    end else if (ctl.load) begin
      row_r <= load_row;
    end else if (ctl.shift) begin
      row_r <= shift_in;
    end
  end

  assign row_out = row_r;

endmodule

// File: rtl/lgs_next_row.sv
// b3/s23 rule for one row from the old rows above, at and below it
module lgs_next_row #(
  parameter int GRID_SIZE = lgs_pkg::GRID_SIZE_DEF
) (
  input  logic [GRID_SIZE-1:0] above,
  input  logic [GRID_SIZE-1:0] mid,
  input  logic [GRID_SIZE-1:0] below,
  output logic [GRID_SIZE-1:0] next_row
);

  localparam int NW = lgs_pkg::NBR_W;

  logic [GRID_SIZE+1:0] above_p;
  logic [GRID_SIZE+1:0] mid_p;
  logic [GRID_SIZE+1:0] below_p;
  logic [NW-1:0]        nbr_cnt [GRID_SIZE];

  // dead cells beyond both edges
  assign above_p = {1'b0, above, 1'b0};
  assign mid_p   = {1'b0, mid, 1'b0};
  assign below_p = {1'b0, below, 1'b0};

  for (genvar c = 0; c < GRID_SIZE; c++) begin : g_col
    assign nbr_cnt[c] = NW'(above_p[c]) + NW'(above_p[c+1]) + NW'(above_p[c+2])
                      + NW'(mid_p[c]) + NW'(mid_p[c+2])
                      + NW'(below_p[c]) + NW'(below_p[c+1]) + NW'(below_p[c+2]);
    assign next_row[c] = (nbr_cnt[c] == lgs_pkg::BIRTH_COUNT)
                      || ((nbr_cnt[c] == lgs_pkg::SURVIVE_COUNT) && mid[c]);
  end

endmodule

// File: rtl/life_grid_generation_step.sv
// Life grid (B3/S23, dead edges, no wrap) held as a ring of GRID_SIZE row registers
// that rotates one row position per clock while it aligns or sweeps. Commands arrive
// on the input stream (in_tuser = command, in_tdata = row and column) and each gives
// one result byte whose bit 0 is the read cell, or 0 for clear, set and advance. A
// clear empties every row as it is accepted and goes straight to the result state.
// A set or read of an in-range cell rotates the ring until the addressed row sits at
// the head, so its length depends on the previous head position; an out-of-range
// coordinate goes straight to the result. An advance first rotates row 0 to the head,
// then sweeps the ring once, one new row per cycle through a three-row window, and
// leaves row 0 at the head again, as it always is after an advance. One command is
// processed at a time; the result register lets the next command enter while a
// result still waits.
`include "life_grid_generation_step_defines.svh"

module life_grid_generation_step #(
  parameter int GRID_SIZE = lgs_pkg::GRID_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // row [5:0], column [11:6]
  input  logic [1:0]  in_tuser,   // command [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // cell_alive [0]
);

  localparam int IDX_W = $clog2(GRID_SIZE);
  localparam int CMP_W = ((lgs_pkg::ROW_W > IDX_W) ? lgs_pkg::ROW_W : IDX_W) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRID_SIZE - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_SWEEP,
    ST_RESP
  } state_t;

  state_t                      state_r;
  lgs_pkg::cmd_t               cmd_r;
  logic [IDX_W-1:0]            row_r;
  logic [IDX_W-1:0]            col_r;
  logic [IDX_W-1:0]            head_idx_r;
  logic                        alive_r;
  logic                        out_valid_r;
  logic                        out_alive_r;
  logic [GRID_SIZE-1:0]        prev_r;

  lgs_pkg::cmd_t               in_cmd;
  logic [lgs_pkg::ROW_W-1:0]   in_row;
  logic [lgs_pkg::COL_W-1:0]   in_col;
  logic                        in_inside;
  logic                        in_accept;
  logic                        at_target;
  logic                        rotate;
  logic                        sweep;
  logic                        clear_all;
  logic                        head_load;
  logic                        resp_load;

  logic [GRID_SIZE-1:0]        ring_row [GRID_SIZE];
  logic [GRID_SIZE-1:0]        win_above;
  logic [GRID_SIZE-1:0]        win_below;
  logic [GRID_SIZE-1:0]        new_row;
  logic [GRID_SIZE-1:0]        tail_in;
  logic [GRID_SIZE-1:0]        head_set_row;
  lgs_pkg::cell_ctl_t          ctl_head;
  lgs_pkg::cell_ctl_t          ctl_rest;

  assign in_cmd    = lgs_pkg::cmd_t'(in_tuser);
  assign in_row    = in_tdata[5:0];
  assign in_col    = in_tdata[11:6];
  assign in_inside = (CMP_W'(in_row) < CMP_W'(GRID_SIZE))
                  && (CMP_W'(in_col) < CMP_W'(GRID_SIZE));
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  assign at_target = (head_idx_r == row_r);
  assign rotate    = (state_r == ST_ALIGN) && !at_target;
  assign sweep     = (state_r == ST_SWEEP);
  assign clear_all = in_accept && (in_cmd == lgs_pkg::CMD_CLEAR);
  assign head_load = (state_r == ST_ALIGN) && at_target && (cmd_r == lgs_pkg::CMD_SET);
  assign resp_load = (state_r == ST_RESP) && (!out_valid_r || out_tready);

  // window of the old generation around the head row
  assign win_above = (head_idx_r == '0) ? '0 : prev_r;
  assign win_below = (head_idx_r == LAST_IDX) ? '0 : ring_row[1];

  lgs_next_row #(
    .GRID_SIZE (GRID_SIZE)
  ) u_next_row (
    .above    (win_above),
    .mid      (ring_row[0]),
    .below    (win_below),
    .next_row (new_row)
  );

  assign tail_in      = sweep ? new_row : ring_row[0];
  assign head_set_row = ring_row[0] | (GRID_SIZE'(1) << col_r);

  assign ctl_head = '{clear: clear_all, shift: rotate || sweep, load: head_load};
  assign ctl_rest = '{clear: clear_all, shift: rotate || sweep, load: 1'b0};

  for (genvar i = 0; i < GRID_SIZE; i++) begin : g_ring
    if (i == 0) begin : g_head
      lgs_row_cell #(
        .GRID_SIZE (GRID_SIZE)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_head),
        .shift_in (ring_row[1]),
        .load_row (head_set_row),
        .row_out  (ring_row[0])
      );
    end else if (i == GRID_SIZE - 1) begin : g_tail
      lgs_row_cell #(
        .GRID_SIZE (GRID_SIZE)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_rest),
        .shift_in (tail_in),
        .load_row ('0),
        .row_out  (ring_row[i])
      );
    end else begin : g_mid
      lgs_row_cell #(
        .GRID_SIZE (GRID_SIZE)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_rest),
        .shift_in (ring_row[i+1]),
        .load_row ('0),
        .row_out  (ring_row[i])
      );
    end
  end

  // old head row becomes the row above for the next sweep step
  always_ff @(posedge clk) begin
    if (sweep) begin
      prev_r <= ring_row[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (rotate || sweep) begin
        head_idx_r <= (head_idx_r == LAST_IDX) ? '0 : head_idx_r + IDX_W'(1);
      end
      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            cmd_r   <= in_cmd;
            row_r   <= IDX_W'(in_row);
            col_r   <= IDX_W'(in_col);
            alive_r <= 1'b0;
            case (in_cmd)
              lgs_pkg::CMD_CLEAR:   state_r <= ST_RESP;
              lgs_pkg::CMD_SET:     state_r <= in_inside ? ST_ALIGN : ST_RESP;
              lgs_pkg::CMD_READ:    state_r <= in_inside ? ST_ALIGN : ST_RESP;
              lgs_pkg::CMD_ADVANCE: begin
                row_r   <= '0;
                state_r <= ST_ALIGN;
              end
              default:              state_r <= ST_RESP;
            endcase
          end
        end
        ST_ALIGN: begin
          if (at_target) begin
            if (cmd_r == lgs_pkg::CMD_ADVANCE) begin
              state_r <= ST_SWEEP;
            end else begin
              if (cmd_r == lgs_pkg::CMD_READ) begin
                alive_r <= ring_row[0][col_r];
              end
              state_r <= ST_RESP;
            end
          end
        end
        ST_SWEEP: begin
          if (head_idx_r == LAST_IDX) begin
            state_r <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (resp_load) begin
            out_alive_r <= alive_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_alive_r};

  `LGS_ASSERT_SAME(a_sweep_cmd, state_r == ST_SWEEP, cmd_r == lgs_pkg::CMD_ADVANCE)
  `LGS_ASSERT_NEXT(a_sweep_end, (state_r == ST_SWEEP) && (head_idx_r == LAST_IDX), (state_r == ST_RESP) && (head_idx_r == '0))
  `LGS_ASSERT_SAME(a_resp_zero, (state_r == ST_RESP) && (cmd_r != lgs_pkg::CMD_READ), !alive_r)
  `LGS_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, !in_tready)

endmodule
